// ----- design/eqfqs_pkg.sv -----
`default_nettype none

package eqfqs_pkg;

	localparam int BOARD_SIZE_DEF = 8;
	localparam int COL_W          = 3;
	localparam int MAX_ROWS       = 8;
	localparam int PLACE_W        = COL_W * MAX_ROWS;

	typedef struct packed {
		logic [COL_W-1:0] fixed_row;
		logic [COL_W-1:0] fixed_col;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [PLACE_W-1:0] placement;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SEARCH
	} state_t;

	// one step of the search engine per cycle; the final step waits for a free output
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_SKIP,
		ACT_NEXT_COL,
		ACT_PLACE,
		ACT_BACK,
		ACT_DONE,
		ACT_FAIL
	} act_t;

endpackage

`default_nettype wire

// ----- design/eight_queens_fixed_queen_search_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  eqfqs_pkg::req_t  (fixed_row, fixed_col)
// rsp       out        rsp_valid / rsp_ready  eqfqs_pkg::rsp_t  (found, placement)
//
// Steps: the fixed queen is loaded first, then one search step per cycle
//   (one column probe, one row advance or one backtrack), set by the single
//   occupancy/index unit; the final step waits until the result register is
//   free, and the result is then registered.
// Reset: arst_n clears the sequencer, the occupancy flags and the result valid.
// Stalls: req_ready is high only while the sequencer is idle; a finished
//   result sits in the output register, and the engine holds on its final
//   step while that register is still full.

module eight_queens_fixed_queen_search_unit #(
	parameter int BOARD_SIZE = eqfqs_pkg::BOARD_SIZE_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire eqfqs_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output eqfqs_pkg::rsp_t      rsp
);

	localparam int DW = 2 * BOARD_SIZE - 1;      // diagonal count
	localparam int SW = $clog2(DW);              // diagonal index width
	localparam int RB = $clog2(BOARD_SIZE);      // row / column index width
	localparam int RW = RB + 2;                  // signed row counter, reaches -1 and N
	localparam int CW = $clog2(BOARD_SIZE + 1);  // column counter, reaches N

	eqfqs_pkg::state_t state_q, state_d;
	eqfqs_pkg::act_t   act;

	logic [eqfqs_pkg::COL_W-1:0] fr_q, fc_q;
	logic signed [RW-1:0]        r_q;
	logic [CW-1:0]               c_q;
	logic [BOARD_SIZE-1:0]       col_used_q;
	logic [DW-1:0]               sum_used_q;
	logic [DW-1:0]               diff_used_q;
	logic [eqfqs_pkg::COL_W-1:0] row_col_q [BOARD_SIZE];
	logic                        rsp_valid_q;
	eqfqs_pkg::rsp_t             rsp_q;

	logic                        out_free;
	logic                        off_board;
	logic signed [RW-1:0]        fr_s;
	logic signed [RW-1:0]        r_m1;
	logic signed [RW-1:0]        rb;
	logic [eqfqs_pkg::COL_W-1:0] cb;
	logic                        col_done;

	// shared occupancy unit
	logic [RB-1:0]         u_row, u_col;
	logic [SW-1:0]         sum_idx, diff_idx;
	logic [BOARD_SIZE-1:0] cm;
	logic [DW-1:0]         sm, dm;
	logic                  sq_free;

	logic [eqfqs_pkg::PLACE_W-1:0] packed_w;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign off_board = ({1'b0, fr_q} >= (eqfqs_pkg::COL_W + 1)'(BOARD_SIZE)) ||
		({1'b0, fc_q} >= (eqfqs_pkg::COL_W + 1)'(BOARD_SIZE));
	assign fr_s      = $signed(RW'(fr_q));
	assign r_m1      = r_q - $signed(RW'(1));
	// backtrack target skips over the fixed row
	assign rb        = (r_m1 == fr_s) ? (r_q - $signed(RW'(2))) : r_m1;
	assign cb        = row_col_q[rb[RB-1:0]];
	assign col_done  = (c_q >= CW'(BOARD_SIZE));

	// operand select: fixed queen on load, backtrack square once a row is
	// exhausted, else the square under probe
	always_comb begin
		if (state_q == eqfqs_pkg::ST_LOAD) begin
			u_row = fr_q[RB-1:0];
			u_col = fc_q[RB-1:0];
		end else if (col_done) begin
			u_row = rb[RB-1:0];
			u_col = cb[RB-1:0];
		end else begin
			u_row = r_q[RB-1:0];
			u_col = c_q[RB-1:0];
		end
	end

	assign sum_idx  = SW'(u_row) + SW'(u_col);
	assign diff_idx = SW'(u_row) + SW'(BOARD_SIZE - 1) - SW'(u_col);
	assign cm       = BOARD_SIZE'(1) << u_col;
	assign sm       = DW'(1) << sum_idx;
	assign dm       = DW'(1) << diff_idx;
	assign sq_free  = !(|(col_used_q & cm)) && !(|(sum_used_q & sm)) &&
		!(|(diff_used_q & dm));

	// rows at or above the board size pack as zero
	always_comb begin
		packed_w = '0;
		for (int k = 0; k < BOARD_SIZE; k++) begin
			packed_w[eqfqs_pkg::COL_W*k +: eqfqs_pkg::COL_W] = row_col_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eqfqs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: picks one step per cycle, holding the final step while the output is full
	always_comb begin
		state_d   = state_q;
		act       = eqfqs_pkg::ACT_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			eqfqs_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = eqfqs_pkg::ST_LOAD;
				end
			end
			eqfqs_pkg::ST_LOAD: begin
				if (!off_board) begin
					act     = eqfqs_pkg::ACT_LOAD;
					state_d = eqfqs_pkg::ST_SEARCH;
				end else if (out_free) begin
					act     = eqfqs_pkg::ACT_FAIL;
					state_d = eqfqs_pkg::ST_IDLE;
				end
			end
			eqfqs_pkg::ST_SEARCH: begin
				if (r_q == fr_s) begin
					act = eqfqs_pkg::ACT_SKIP;
				end else if (r_q >= $signed(RW'(BOARD_SIZE))) begin
					if (out_free) begin
						act     = eqfqs_pkg::ACT_DONE;
						state_d = eqfqs_pkg::ST_IDLE;
					end
				end else if (!col_done) begin
					act = sq_free ? eqfqs_pkg::ACT_PLACE : eqfqs_pkg::ACT_NEXT_COL;
				end else if (!rb[RW-1]) begin
					act = eqfqs_pkg::ACT_BACK;
				end else if (out_free) begin
					act     = eqfqs_pkg::ACT_FAIL;
					state_d = eqfqs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = eqfqs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q         <= '0;
			c_q         <= '0;
			col_used_q  <= '0;
			sum_used_q  <= '0;
			diff_used_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (act)
				eqfqs_pkg::ACT_LOAD: begin
					col_used_q  <= cm;
					sum_used_q  <= sm;
					diff_used_q <= dm;
					r_q         <= '0;
					c_q         <= '0;
				end
				eqfqs_pkg::ACT_SKIP: begin
					r_q <= r_q + $signed(RW'(1));
					c_q <= '0;
				end
				eqfqs_pkg::ACT_NEXT_COL: begin
					c_q <= c_q + CW'(1);
				end
				eqfqs_pkg::ACT_PLACE: begin
					col_used_q  <= col_used_q | cm;
					sum_used_q  <= sum_used_q | sm;
					diff_used_q <= diff_used_q | dm;
					r_q         <= r_q + $signed(RW'(1));
					c_q         <= '0;
				end
				eqfqs_pkg::ACT_BACK: begin
					col_used_q  <= col_used_q & ~cm;
					sum_used_q  <= sum_used_q & ~sm;
					diff_used_q <= diff_used_q & ~dm;
					r_q         <= rb;
					c_q         <= CW'(cb) + CW'(1);
				end
				eqfqs_pkg::ACT_DONE,
				eqfqs_pkg::ACT_FAIL: begin
					rsp_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			fr_q <= req.fixed_row;
			fc_q <= req.fixed_col;
		end
		if (act == eqfqs_pkg::ACT_LOAD || act == eqfqs_pkg::ACT_PLACE) begin
			row_col_q[u_row] <= eqfqs_pkg::COL_W'(u_col);
		end
		if (act == eqfqs_pkg::ACT_DONE) begin
			rsp_q.found     <= 1'b1;
			rsp_q.placement <= packed_w;
		end else if (act == eqfqs_pkg::ACT_FAIL) begin
			rsp_q.found     <= 1'b0;
			rsp_q.placement <= '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// the row counter never goes negative while searching
	a_row_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == eqfqs_pkg::ST_SEARCH) |-> !r_q[RW-1])
		else $error("row counter negative during search");

	// every queen occupies exactly one column and one diagonal of each kind
	a_flags_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == eqfqs_pkg::ST_SEARCH) |->
		($countones(col_used_q) == $countones(sum_used_q)) &&
		($countones(col_used_q) == $countones(diff_used_q)))
		else $error("occupancy flags out of step");

	// a found result carries a full board of queens
	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp_valid_q) && rsp_q.found) |->
		($countones(col_used_q) == BOARD_SIZE))
		else $error("found reported with incomplete placement");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BOARD      = eqfqs_pkg::BOARD_SIZE_DEF;
	localparam int RAND_ITEMS = 140;
	// No transfer on either side for this long means the block is hung.
	// The worst search and the long output hold-off both stay well under this limit.
	localparam int STALL_LIMIT = 200000;
	localparam int HOLD_OFF    = 6000;
	localparam int DRAIN       = 100;

	// Scoreboard: predicts each solved board at request time, checks answers in order.
	class queens_scoreboard;
		eqfqs_pkg::rsp_t expected_boards[$];
		int   errors;
		int   answers;

		function new();
			errors  = 0;
			answers = 0;
		endfunction

		// Depth-first search, rows upward, columns upward, fixed row skipped.
		function eqfqs_pkg::rsp_t solve_board(eqfqs_pkg::req_t q);
			bit [7:0]  col_used;
			bit [14:0] sum_used;
			bit [14:0] diff_used;
			bit [2:0]  col_of [8];
			int        fr, fc, r, c, k;
			bit        solved, stop;
			eqfqs_pkg::rsp_t res;
			col_used  = '0;
			sum_used  = '0;
			diff_used = '0;
			for (k = 0; k < 8; k++)
				col_of[k] = '0;
			fr     = int'(q.fixed_row);
			fc     = int'(q.fixed_col);
			r      = 0;
			c      = 0;
			solved = 1'b0;
			stop   = 1'b0;
			res    = '0;
			if (fr < BOARD && fc < BOARD) begin
				col_used[fc]               = 1'b1;
				sum_used[fr + fc]          = 1'b1;
				diff_used[fr - fc + BOARD - 1] = 1'b1;
				col_of[fr]                 = fc[2:0];
				while (!stop) begin
					if (r == fr) begin
						r++;
						c = 0;
					end else if (r >= BOARD) begin
						solved = 1'b1;
						stop   = 1'b1;
					end else begin
						while (c < BOARD && (col_used[c] || sum_used[r + c] ||
								diff_used[r - c + BOARD - 1]))
							c++;
						if (c < BOARD) begin
							col_used[c]               = 1'b1;
							sum_used[r + c]           = 1'b1;
							diff_used[r - c + BOARD - 1] = 1'b1;
							col_of[r]                 = c[2:0];
							r++;
							c = 0;
						end else begin
							// dead end: step back, hopping over the fixed row
							r--;
							if (r == fr)
								r--;
							if (r < 0) begin
								stop = 1'b1;
							end else begin
								c = int'(col_of[r]);
								col_used[c]               = 1'b0;
								sum_used[r + c]           = 1'b0;
								diff_used[r - c + BOARD - 1] = 1'b0;
								c++;
							end
						end
					end
				end
			end
			res.found = solved;
			if (solved)
				for (k = 0; k < BOARD; k++)
					res.placement[3*k +: 3] = col_of[k];
			return res;
		endfunction

		function void note_request(eqfqs_pkg::req_t q);
			expected_boards.push_back(solve_board(q));
		endfunction

		function void check_answer(eqfqs_pkg::rsp_t got);
			eqfqs_pkg::rsp_t exp_board;
			answers++;
			if (expected_boards.size() == 0) begin
				errors++;
				$display("%0t: answer with none pending: found=%0d placement=%06h",
					$time, got.found, got.placement);
				return;
			end
			exp_board = expected_boards.pop_front();
			if (got.found !== exp_board.found) begin
				errors++;
				$display("%0t: found expected %0d actual %0d",
					$time, exp_board.found, got.found);
			end
			if (got.placement !== exp_board.placement) begin
				errors++;
				$display("%0t: placement expected %06h actual %06h",
					$time, exp_board.placement, got.placement);
			end
		endfunction

		function int pending();
			return expected_boards.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	eqfqs_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	eqfqs_pkg::rsp_t rsp;

	queens_scoreboard sb;
	int idle_cycles;

	eight_queens_fixed_queen_search_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 20);
		else
			return $urandom_range(50, 300);
	endfunction

	// Drive one request at the falling edge and hold it until the transfer.
	// With gap 0 valid stays high and only the payload moves on.
	task automatic send_request(input eqfqs_pkg::req_t item, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic send_square(input int row, input int col, input int gap);
		eqfqs_pkg::req_t item;
		item.fixed_row = row[2:0];
		item.fixed_col = col[2:0];
		send_request(item, gap);
	endtask

	// Monitor: sample both channels at the rising edge. Inputs only move on the
	// falling edge, so values read here are stable. Also runs the hang watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_answer(rsp);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Result side: random ready pattern, independent of rsp_valid, so stalls land
	// on any phase of the search. Answers 30..49 see ready held high. Once, after
	// 20 answers, ready drops for a long stretch so the result register fills, the
	// engine parks on its last step and req_ready falls while requests keep coming.
	initial begin : answer_sink
		int  hold;
		int  gap;
		bit  long_stall_done;
		hold            = 0;
		long_stall_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!long_stall_done && sb.answers >= 20) begin
				long_stall_done = 1'b1;
				hold            = HOLD_OFF - 1;
				rsp_ready      <= 1'b0;
			end else if (sb.answers >= 30 && sb.answers < 50) begin
				rsp_ready <= 1'b1;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					hold       = gap - 1;
					rsp_ready <= 1'b0;
				end else begin
					rsp_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : request_source
		eqfqs_pkg::req_t item;
		int   i;
		bit   quiet;

		clk         = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		rsp_ready   = 1'b0;
		req         = '0;
		idle_cycles = 0;
		sb          = new();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: corners, edge midpoints, the center and the two main diagonals.
		send_square(0, 0, 0);
		send_square(0, 7, 0);
		send_square(7, 0, 2);
		send_square(7, 7, 0);
		send_square(0, 3, 1);
		send_square(3, 0, 0);
		send_square(7, 4, 0);
		send_square(4, 7, 5);
		send_square(3, 3, 0);
		send_square(4, 4, 0);
		send_square(2, 5, 0);
		send_square(5, 2, 3);
		send_square(1, 6, 0);
		send_square(6, 1, 0);
		send_square(5, 5, 0);
		send_square(2, 2, 1);

		// Random squares; items 40..69 go back to back with no sender gaps.
		for (i = 0; i < RAND_ITEMS; i++) begin
			quiet          = (i >= 40 && i < 70);
			item.fixed_row = 3'($urandom_range(0, 7));
			item.fixed_col = 3'($urandom_range(0, 7));
			send_request(item, quiet ? 0 : pick_gap());
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// Drain: every answer back, then a margin for any stray transfer.
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
